// ===== rtl/grcw_pkg.sv =====
// grcw_pkg: types, widths and constants for the grid ray cell walk core
// used by grcw_ctrl, grcw_dp and grid_ray_cell_walk_core
`default_nettype none

package grcw_pkg;

  localparam int DIMS               = 3;
  localparam int MAX_CELLS_PER_AXIS = 32;
  localparam int MAX_RESULTS        = 41;

  localparam int NAX     = 3;
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int CS_W    = 16;
  localparam int NC_W    = 6;
  localparam int CELL_W  = 5;
  localparam int CFG_IW  = 3;
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int QB      = $clog2(MAX_CELLS_PER_AXIS);
  localparam int DVD_W   = COORD_W + 3;
  localparam int DVS_W   = CS_W + 2;
  localparam int CNT_W   = DVD_W;
  localparam int DEN_W   = DVD_W - 2;
  localparam int Q_W     = DIFF_W + CNT_W + 1;
  localparam int STEP_W  = $clog2(DVD_W);

  localparam logic [CFG_IW-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CELL_SIZE = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CELLS_X   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CELLS_Y   = 3'd5;
  localparam logic [CFG_IW-1:0] REG_CELLS_Z   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MULI,
    ST_MUL,
    ST_ADV,
    ST_CHK,
    ST_QDIV,
    ST_DECIDE,
    ST_EMIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [NAX-1:0][COORD_W-1:0] org;
    logic [CS_W-1:0]             cell_size;
    logic [NAX-1:0][NC_W-1:0]    ncells;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic adv;
    logic qinit;
    logic q_step;
    logic take;
    logic emit_pend;
    logic emit_fin;
  } cmd_t;

  typedef struct packed {
    logic n_ge;
    logic nres_full;
    logic outside;
    logic same;
    logic pend_vld;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/grcw_ctrl.sv =====
// grcw_ctrl: sequencer for the grid ray cell walk, owns the output valid
// depends on grcw_pkg; drives grcw_dp through cmd_t, reads sts_t
`default_nettype none

module grcw_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  input  grcw_pkg::sts_t   sts_i,
  output grcw_pkg::cmd_t   cmd_o
);
  import grcw_pkg::*;

  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_vld_q, out_vld_d;
  logic                out_free;

  assign out_free = !out_vld_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_PREP;
      ST_PREP:   state_d = ST_DIV;
      ST_DIV:    if (step_q == STEP_W'(DVD_W - 1)) state_d = ST_MULI;
      ST_MULI:   state_d = ST_MUL;
      ST_MUL:    if (step_q == STEP_W'(CNT_W - 1)) state_d = ST_ADV;
      ST_ADV:    state_d = ST_CHK;
      ST_CHK: begin
        if (sts_i.n_ge || sts_i.nres_full) state_d = ST_FIN;
        else                               state_d = ST_QDIV;
      end
      ST_QDIV:   if (step_q == STEP_W'(QB - 1)) state_d = ST_DECIDE;
      ST_DECIDE: begin
        priority if (sts_i.outside) state_d = ST_FIN;
        else if (sts_i.same)        state_d = ST_ADV;
        else if (sts_i.pend_vld)    state_d = ST_EMIT;
        else                        state_d = ST_ADV;
      end
      ST_EMIT:   if (out_free) state_d = ST_ADV;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    step_d     = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      ST_PREP:  cmd_o.prep = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
      end
      ST_MULI:  cmd_o.mul_init = 1'b1;
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        step_d         = step_q + 1'b1;
      end
      ST_ADV:   cmd_o.adv = 1'b1;
      ST_CHK:   cmd_o.qinit = !(sts_i.n_ge || sts_i.nres_full);
      ST_QDIV: begin
        cmd_o.q_step = 1'b1;
        step_d       = step_q + 1'b1;
      end
      ST_DECIDE: cmd_o.take = !sts_i.outside && !sts_i.same && !sts_i.pend_vld;
      ST_EMIT: begin
        cmd_o.take      = out_free;
        cmd_o.emit_pend = out_free;
      end
      ST_FIN:   cmd_o.emit_fin = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.emit_pend || cmd_o.emit_fin) out_vld_d = 1'b1;
    else if (!out_stall_i)                 out_vld_d = 1'b0;
    else                                   out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// ===== rtl/grcw_dp.sv =====
// grcw_dp: datapath of the grid ray cell walk: count divider, serial
// multipliers, sample accumulators, cell index dividers and output register
// depends on grcw_pkg; controlled by grcw_ctrl
`default_nettype none

module grcw_dp (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  grcw_pkg::cfg_t               cfg_i,
  input  wire signed [grcw_pkg::COORD_W-1:0] start_x_i,
  input  wire signed [grcw_pkg::COORD_W-1:0] start_y_i,
  input  wire signed [grcw_pkg::COORD_W-1:0] start_z_i,
  input  wire signed [grcw_pkg::COORD_W-1:0] end_x_i,
  input  wire signed [grcw_pkg::COORD_W-1:0] end_y_i,
  input  wire signed [grcw_pkg::COORD_W-1:0] end_z_i,
  input  grcw_pkg::cmd_t               cmd_i,
  output grcw_pkg::sts_t               sts_o,
  output logic [grcw_pkg::CELL_W-1:0]  cell_x_o,
  output logic [grcw_pkg::CELL_W-1:0]  cell_y_o,
  output logic [grcw_pkg::CELL_W-1:0]  cell_z_o,
  output logic                         cell_valid_o,
  output logic                         last_o
);
  import grcw_pkg::*;

  logic signed [COORD_W-1:0] st_in [NAX];
  logic signed [COORD_W-1:0] en_in [NAX];

  logic signed [COORD_W-1:0] st_q [NAX];
  logic signed [DIFF_W-1:0]  df_q [NAX];
  logic [DVD_W-1:0]          m5_q, dvd_q;
  logic [DVS_W-1:0]          rem_q;
  logic [CNT_W-1:0]          count_q, mlt_q, n_q;
  logic [DEN_W-1:0]          den_q;
  logic signed [Q_W-1:0]     mc_q [NAX];
  logic signed [Q_W-1:0]     q_q  [NAX];
  logic [Q_W-1:0]            rq_q [NAX];
  logic [Q_W-1:0]            dsh_q;
  logic                      bad_q [NAX];
  logic [QB-1:0]             idx_q [NAX];
  logic [CELL_W-1:0]         pend_q [NAX];
  logic                      pend_vld_q;
  logic [RES_W-1:0]          nres_q;
  logic [CELL_W-1:0]         out_cell_q [NAX];
  logic                      out_cv_q, out_last_q;

  logic [COORD_W-1:0]        m_w;
  logic [DIFF_W-1:0]         mg;
  logic [DVD_W-1:0]          m5_w;
  logic [CS_W-1:0]           cs_eff;
  logic [DVS_W:0]            tr, dvs_x;
  logic                      dv_ge;
  logic [Q_W-1:0]            den_lim;
  logic [NC_W-1:0]           lim [NAX];
  logic                      outside, same;
  logic signed [DIFF_W-1:0]  rel [NAX];

  assign st_in[0] = start_x_i;
  assign st_in[1] = start_y_i;
  assign st_in[2] = start_z_i;
  assign en_in[0] = end_x_i;
  assign en_in[1] = end_y_i;
  assign en_in[2] = end_z_i;

  // largest axis difference over the active axes
  always_comb begin
    m_w = '0;
    mg  = '0;
    for (int a = 0; a < NAX; a++) begin
      mg = df_q[a][DIFF_W-1] ? DIFF_W'(-df_q[a]) : DIFF_W'(df_q[a]);
      if (a < DIMS && mg[COORD_W-1:0] > m_w) m_w = mg[COORD_W-1:0];
    end
    m5_w = (DVD_W'(m_w) << 2) + DVD_W'(m_w);
  end

  assign cs_eff  = (cfg_i.cell_size == '0) ? CS_W'(1) : cfg_i.cell_size;
  assign dvs_x   = {1'b0, cs_eff, 2'b00};
  assign tr      = {rem_q, dvd_q[DVD_W-1]};
  assign dv_ge   = tr >= dvs_x;
  assign den_lim = Q_W'(den_q) << QB;

  always_comb begin
    outside = 1'b0;
    same    = pend_vld_q;
    for (int a = 0; a < NAX; a++) begin
      lim[a] = (cfg_i.ncells[a] > NC_W'(MAX_CELLS_PER_AXIS)) ?
               NC_W'(MAX_CELLS_PER_AXIS) : cfg_i.ncells[a];
      rel[a] = DIFF_W'(st_q[a]) - DIFF_W'($signed(cfg_i.org[a]));
      if (a < DIMS) begin
        if (bad_q[a] || (NC_W'(idx_q[a]) >= lim[a])) outside = 1'b1;
        if (CELL_W'(idx_q[a]) != pend_q[a]) same = 1'b0;
      end
    end
  end

  assign sts_o.n_ge      = n_q >= count_q;
  assign sts_o.nres_full = nres_q == RES_W'(MAX_RESULTS);
  assign sts_o.outside   = outside;
  assign sts_o.same      = same;
  assign sts_o.pend_vld  = pend_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      nres_q     <= '0;
    end else begin
      if (cmd_i.mul_init) begin
        pend_vld_q <= 1'b0;
        nres_q     <= '0;
      end else if (cmd_i.take) begin
        pend_vld_q <= 1'b1;
        nres_q     <= nres_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < NAX; a++) begin
        st_q[a] <= st_in[a];
        df_q[a] <= DIFF_W'(en_in[a]) - DIFF_W'(st_in[a]);
      end
    end
    if (cmd_i.prep) begin
      m5_q  <= m5_w;
      dvd_q <= m5_w;
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= dv_ge ? DVS_W'(tr - dvs_x) : DVS_W'(tr);
      dvd_q <= {dvd_q[DVD_W-2:0], dv_ge};
    end
    if (cmd_i.mul_init) begin
      count_q <= dvd_q;
      mlt_q   <= dvd_q;
      n_q     <= '0;
      den_q   <= DEN_W'((m5_q - DVD_W'(rem_q)) >> 2);
      for (int a = 0; a < NAX; a++) begin
        mc_q[a] <= Q_W'(rel[a]);
        q_q[a]  <= '0;
      end
    end
    if (cmd_i.mul_step) begin
      mlt_q <= mlt_q >> 1;
      for (int a = 0; a < NAX; a++) begin
        mc_q[a] <= mc_q[a] <<< 1;
        if (mlt_q[0]) q_q[a] <= q_q[a] + mc_q[a];
      end
    end
    if (cmd_i.adv) begin
      n_q <= n_q + 1'b1;
      for (int a = 0; a < NAX; a++) q_q[a] <= q_q[a] + Q_W'(df_q[a]);
    end
    if (cmd_i.qinit) begin
      dsh_q <= Q_W'(den_q) << (QB - 1);
      for (int a = 0; a < NAX; a++) begin
        rq_q[a]  <= q_q[a];
        idx_q[a] <= '0;
        bad_q[a] <= (q_q[a] <= 0) || (q_q[a] >= $signed(den_lim));
      end
    end
    if (cmd_i.q_step) begin
      dsh_q <= dsh_q >> 1;
      for (int a = 0; a < NAX; a++) begin
        if (rq_q[a] >= dsh_q) begin
          rq_q[a]  <= rq_q[a] - dsh_q;
          idx_q[a] <= QB'({idx_q[a], 1'b1});
        end else begin
          idx_q[a] <= QB'({idx_q[a], 1'b0});
        end
      end
    end
    if (cmd_i.take) begin
      for (int a = 0; a < NAX; a++)
        pend_q[a] <= (a < DIMS) ? CELL_W'(idx_q[a]) : '0;
    end
    if (cmd_i.emit_pend) begin
      out_cell_q <= pend_q;
      out_cv_q   <= 1'b1;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_fin) begin
      for (int a = 0; a < NAX; a++)
        out_cell_q[a] <= pend_vld_q ? pend_q[a] : '0;
      out_cv_q   <= pend_vld_q;
      out_last_q <= 1'b1;
    end
  end

  assign cell_x_o     = out_cell_q[0];
  assign cell_y_o     = out_cell_q[1];
  assign cell_z_o     = out_cell_q[2];
  assign cell_valid_o = out_cv_q;
  assign last_o       = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/grid_ray_cell_walk_core.sv =====
// grid_ray_cell_walk_core: top level, configuration registers, sequencer
// and datapath of the grid ray cell walk; depends on grcw_pkg, grcw_ctrl, grcw_dp
//
//  channel  handshake              payload
//  in       in_valid_i/in_stall_o  start_x/y/z_i, end_x/y/z_i
//  out      out_valid_o/out_stall_i cell_x/y/z_o, cell_valid_o, last_o
//  cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one segment at a time: setup, sample count division, serial start products,
// then per sample advance, range check, 5 index division steps and decision,
// one more step when a new cell is sent, plus a wait while the output
// register is stalled
// reset clears config to origin 0, cell size 1.0, 32 cells per axis
`default_nettype none

module grid_ray_cell_walk_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [grcw_pkg::CFG_IW-1:0]          cfg_index_i,
  input  wire [grcw_pkg::COORD_W-1:0]         cfg_data_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire signed [grcw_pkg::COORD_W-1:0]  start_x_i,
  input  wire signed [grcw_pkg::COORD_W-1:0]  start_y_i,
  input  wire signed [grcw_pkg::COORD_W-1:0]  start_z_i,
  input  wire signed [grcw_pkg::COORD_W-1:0]  end_x_i,
  input  wire signed [grcw_pkg::COORD_W-1:0]  end_y_i,
  input  wire signed [grcw_pkg::COORD_W-1:0]  end_z_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic [grcw_pkg::CELL_W-1:0]         cell_x_o,
  output logic [grcw_pkg::CELL_W-1:0]         cell_y_o,
  output logic [grcw_pkg::CELL_W-1:0]         cell_z_o,
  output logic                                cell_valid_o,
  output logic                                last_o
);
  import grcw_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.org       <= '0;
      cfg_q.cell_size <= CS_W'(256);
      cfg_q.ncells    <= {NAX{NC_W'(32)}};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ORIGIN_X:  cfg_q.org[0]     <= cfg_data_i;
        REG_ORIGIN_Y:  cfg_q.org[1]     <= cfg_data_i;
        REG_ORIGIN_Z:  cfg_q.org[2]     <= cfg_data_i;
        REG_CELL_SIZE: cfg_q.cell_size  <= cfg_data_i[CS_W-1:0];
        REG_CELLS_X:   cfg_q.ncells[0]  <= cfg_data_i[NC_W-1:0];
        REG_CELLS_Y:   cfg_q.ncells[1]  <= cfg_data_i[NC_W-1:0];
        REG_CELLS_Z:   cfg_q.ncells[2]  <= cfg_data_i[NC_W-1:0];
        default: ;
      endcase
    end
  end

  grcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  grcw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_z_i      (end_z_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .cell_z_o     (cell_z_o),
    .cell_valid_o (cell_valid_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire
